// ===== rtl/wbps_pkg.sv =====
// Shared types, constants and helpers for the wildcard byte pattern scanner.
// Used by wbps_cell and wildcard_byte_pattern_scan; no dependencies.
package wbps_pkg;

  // Default window depth in bytes
  localparam int unsigned PAT_BYTES_DEF = 32;
  // Pattern bytes held by the configuration words
  localparam int unsigned REG_PAT_BYTES = 32;
  localparam int unsigned PAT_IDX_W     = $clog2(REG_PAT_BYTES);
  localparam int unsigned PAT_WORDS     = 4;
  localparam int unsigned WORD_W        = 64;
  // Wide enough for any pattern index or length up to the largest window
  localparam int unsigned IDX_W         = 7;

  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_LEN_W = 6;
  localparam int unsigned OFF_W     = 32;

  localparam logic [CFG_LEN_W-1:0] LEN_RESET = CFG_LEN_W'(27);
  localparam logic [7:0]           WILDCARD  = 8'hFF;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT0 = 3'd0,
    REG_PAT1 = 3'd1,
    REG_PAT2 = 3'd2,
    REG_PAT3 = 3'd3,
    REG_LEN  = 3'd4,
    REG_BASE = 3'd5
  } cfg_reg_t;

  // Per-cell control: shift enable, cell inside pattern length, its pattern byte
  typedef struct packed {
    logic       shift;
    logic       active;
    logic [7:0] pat;
  } cell_ctl_t;

  // Pick pattern byte k; bytes beyond the configuration words are wildcards
  function automatic logic [7:0] pat_pick(
    input logic [8*REG_PAT_BYTES-1:0] pat_vec,
    input logic [IDX_W-1:0]           k
  );
    return (k >= IDX_W'(REG_PAT_BYTES)) ? WILDCARD : pat_vec[k[PAT_IDX_W-1:0]*8 +: 8];
  endfunction

endpackage

// ===== rtl/wbps_cell.sv =====
// One window cell: holds one byte of the sliding window and its pattern byte.
// Depends on wbps_pkg for cell_ctl_t and the wildcard constant.
module wbps_cell import wbps_pkg::*; (
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  logic [7:0] byte_in,
  output logic [7:0] byte_out,
  output logic       eq
);

  logic [7:0] byte_r;
  logic [7:0] pat_r;
  logic       care_r;

  // Advance the window byte toward the older neighbor
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      byte_r <= byte_in;
    end
  end

  // Track the pattern byte this cell compares against
  always_ff @(posedge clk) begin
    pat_r  <= ctl.pat;
    care_r <= ctl.active && (ctl.pat != WILDCARD);
  end

  assign byte_out = byte_r;
  assign eq       = !care_r || (byte_r == pat_r);

endmodule

// ===== rtl/wildcard_byte_pattern_scan.sv =====
// Top level of the wildcard byte pattern scanner: config registers, cell chain,
// result stage. Depends on wbps_pkg and wbps_cell.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one region byte per word,
//   with in_last_byte marking the final byte of a region. The result channel
//   (out_valid/out_ready) carries at most one word per region: found = 1 with
//   match_offset = offset_base + start of the first match, or found = 0 and
//   offset 0 when the region ends without a match. Bytes after a match are
//   taken and dropped until the end of the region.
//   Throughput is one byte per cycle while the result channel does not stall.
//   The edge that accepts a byte shifts it into the cell chain; the parallel
//   window compare and the offset add then load the output register, which
//   drives out_valid, once it is free. The compare result feeds the shift
//   enable of the next byte in the same cycle.
//   While out_valid is high and out_ready is low, one more byte can be taken
//   and held in the compare stage; after that in_ready drops until the
//   output register is emptied.
//   Reset (rst_n low at a clock edge) empties both stages, rearms the scan
//   and loads the register defaults (pattern length 27, all else zero).
//   Make configuration writes (cfg_we) only while the scanner is idle.
module wildcard_byte_pattern_scan import wbps_pkg::*; #(
  parameter int unsigned PATTERN_BYTES = PAT_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_last_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_found,
  output logic [OFF_W-1:0]     out_match_offset
);

  localparam int unsigned LEN_W = $clog2(PATTERN_BYTES + 1);

  // Configuration registers
  logic [PAT_WORDS*WORD_W-1:0] pat_vec_r;
  logic [CFG_LEN_W-1:0]        cfg_len_r;
  logic [OFF_W-1:0]            base_r;

  // Scan state
  logic [LEN_W-1:0] fill_r,  fill_nxt;
  logic [OFF_W-1:0] pos_r,   pos_nxt;
  logic             done_r,  done_nxt;
  logic             rearm_r, rearm_nxt;

  // Compare stage
  logic             pend_vld_r,   pend_vld_nxt;
  logic             pend_last_r;
  logic [OFF_W-1:0] pend_start_r;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r;
  logic [OFF_W-1:0] out_match_offset_r;

  logic [IDX_W-1:0]       len_ext;
  logic [IDX_W-1:0]       len_clip;
  logic [LEN_W-1:0]       len_used;
  logic [LEN_W-1:0]       fill_base;
  logic [OFF_W-1:0]       here;
  logic [PATTERN_BYTES-1:0] cell_eq;
  logic [7:0]             win_byte [PATTERN_BYTES];
  logic                   hit;
  logic                   pend_hit;
  logic                   done_eff;
  logic                   shift_en;
  logic                   in_acc;
  logic                   out_free;
  logic                   pend_adv;
  logic                   out_load;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_vec_r <= '0;
      cfg_len_r <= LEN_RESET;
      base_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAT0: pat_vec_r[0*WORD_W +: WORD_W] <= cfg_wdata;
        REG_PAT1: pat_vec_r[1*WORD_W +: WORD_W] <= cfg_wdata;
        REG_PAT2: pat_vec_r[2*WORD_W +: WORD_W] <= cfg_wdata;
        REG_PAT3: pat_vec_r[3*WORD_W +: WORD_W] <= cfg_wdata;
        REG_LEN:  cfg_len_r <= cfg_wdata[CFG_LEN_W-1:0];
        REG_BASE: base_r    <= cfg_wdata[OFF_W-1:0];
        default:  ;
      endcase
    end
  end

  // Clip the pattern length to 1..PATTERN_BYTES
  always_comb begin
    len_ext = IDX_W'(cfg_len_r);
    if (cfg_len_r == '0) begin
      len_clip = IDX_W'(1);
    end else if (len_ext > IDX_W'(PATTERN_BYTES)) begin
      len_clip = IDX_W'(PATTERN_BYTES);
    end else begin
      len_clip = len_ext;
    end
    len_used = len_clip[LEN_W-1:0];
  end

  // Handshake and stage control
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !pend_vld_r || out_free;
  assign in_acc   = in_valid && in_ready;
  assign pend_adv = pend_vld_r && out_free;

  // Window compare for the word in the compare stage
  assign hit      = (fill_r >= len_used) && (&cell_eq);
  assign pend_hit = pend_vld_r && hit;
  assign out_load = pend_adv && (hit || pend_last_r);

  // A fresh region never skips; otherwise skip once a match is known
  assign done_eff = !rearm_r && (done_r || pend_hit);
  assign shift_en = in_acc && !done_eff;

  // Cell chain: newest byte enters cell 0
  for (genvar j = 0; j < PATTERN_BYTES; j++) begin : g_cell
    cell_ctl_t        ctl;
    logic [7:0]       byte_in;
    logic [IDX_W-1:0] k;

    always_comb begin
      k          = IDX_W'(len_used) - IDX_W'(j) - IDX_W'(1);
      ctl.shift  = shift_en;
      ctl.active = IDX_W'(j) < IDX_W'(len_used);
      ctl.pat    = pat_pick(pat_vec_r[8*REG_PAT_BYTES-1:0], k);
    end

    if (j == 0) begin : g_head
      assign byte_in = in_data_byte;
    end else begin : g_link
      assign byte_in = win_byte[j-1];
    end

    wbps_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .byte_in  (byte_in),
      .byte_out (win_byte[j]),
      .eq       (cell_eq[j])
    );
  end

  // Next scan state
  always_comb begin
    fill_base = rearm_r ? '0 : fill_r;
    here      = rearm_r ? '0 : pos_r;
    fill_nxt  = fill_r;
    pos_nxt   = pos_r;
    done_nxt  = done_r;
    rearm_nxt = rearm_r;
    if (in_acc) begin
      rearm_nxt = in_last_byte;
      done_nxt  = in_last_byte ? 1'b0 : done_eff;
      if (!done_eff) begin
        fill_nxt = (fill_base == LEN_W'(PATTERN_BYTES)) ? fill_base
                                                        : fill_base + LEN_W'(1);
        pos_nxt  = here + OFF_W'(1);
      end
    end else if (pend_adv && hit && !pend_last_r) begin
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      pos_r   <= '0;
      done_r  <= 1'b0;
      rearm_r <= 1'b1;
    end else begin
      fill_r  <= fill_nxt;
      pos_r   <= pos_nxt;
      done_r  <= done_nxt;
      rearm_r <= rearm_nxt;
    end
  end

  // Compare stage: hold the word that was just shifted in
  always_comb begin
    pend_vld_nxt = pend_vld_r;
    if (shift_en) begin
      pend_vld_nxt = 1'b1;
    end else if (pend_adv) begin
      pend_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
    end else begin
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      pend_last_r  <= in_last_byte;
      pend_start_r <= here - OFF_W'(len_used) + OFF_W'(1);
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r        <= hit;
      out_match_offset_r <= hit ? (base_r + pend_start_r) : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_match_offset = out_match_offset_r;

`ifndef SYNTH
  // Window fill never passes the window depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LEN_W'(PATTERN_BYTES))
    else $error("fill count above window depth");

  // A pending final byte always leaves the scan rearmed
  a_last_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_vld_r && pend_last_r) |-> rearm_r)
    else $error("final byte pending without rearm");

  // Bytes skipped after a match never reach the compare stage
  a_skip_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !shift_en) |=> !pend_vld_r)
    else $error("skipped byte entered compare stage");

  // A not-found word carries a zero offset
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_match_offset_r == '0))
    else $error("not-found word with nonzero offset");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking bench for wildcard_byte_pattern_scan: a directed burst of regions,
// then randomized register phases with planted and noise regions under random flow.
// Depends on wbps_pkg and the scanner RTL only.
module testbench;
  import wbps_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } region_word_t;

  typedef struct {
    logic             found;
    logic [OFF_W-1:0] offset;
  } scan_report_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  cfg_reg_t             cfg_index = REG_PAT0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_data_byte = 8'h00;
  logic                 in_last_byte = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_found;
  logic [OFF_W-1:0]     out_match_offset;

  // Shadow registers and scan state of the predictor
  logic [WORD_W-1:0]    pat_word [PAT_WORDS];
  logic [CFG_LEN_W-1:0] len_reg;
  logic [OFF_W-1:0]     base_reg;
  logic [7:0]           win [32];
  int unsigned          win_fill;
  logic [31:0]          region_pos;
  bit                   region_hit;

  region_word_t         region_words_q [$];
  scan_report_t         expected_reports [$];

  int                   mismatch_count = 0;
  int                   hits_seen = 0;
  int                   misses_seen = 0;
  int                   regions_sent = 0;
  int                   settings_used = 0;

  wildcard_byte_pattern_scan dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_match_offset (out_match_offset)
  );

  always #2 clk = ~clk;

  // Pattern byte k of the shadow registers
  function automatic logic [7:0] pat_byte(input int unsigned k);
    return pat_word[k / 8][(k % 8) * 8 +: 8];
  endfunction

  // Clamp the length register into 1..32
  function automatic int unsigned eff_len();
    if (len_reg == '0) return 1;
    if (len_reg > 6'd32) return 32;
    return len_reg;
  endfunction

  function automatic void rearm_scan();
    for (int k = 0; k < 32; k++) win[k] = 8'h00;
    win_fill = 0;
    region_pos = '0;
    region_hit = 1'b0;
  endfunction

  // Advance the scan by one word and queue the report it causes, if any
  function automatic void scan_byte(input logic [7:0] data, input logic last);
    int unsigned  len;
    logic [31:0]  here;
    bit           hit;
    scan_report_t rep;
    len = eff_len();
    here = region_pos;
    if (!region_hit) begin
      for (int k = 31; k > 0; k--) win[k] = win[k-1];
      win[0] = data;
      if (win_fill < 32) win_fill++;
      region_pos = region_pos + 32'd1;
      hit = (win_fill >= len);
      for (int k = 0; k < len; k++) begin
        if (pat_byte(k) != WILDCARD && pat_byte(k) != win[len-1-k]) hit = 1'b0;
      end
      if (hit) begin
        rep.found = 1'b1;
        rep.offset = base_reg + (here - 32'(len - 1));
        region_hit = 1'b1;
        expected_reports.push_back(rep);
      end else if (last) begin
        rep.found = 1'b0;
        rep.offset = '0;
        expected_reports.push_back(rep);
      end
    end
    if (last) rearm_scan();
  endfunction

  // Driver: bursts of words with random gaps, payload held while stalled
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk) begin
    region_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) scan_byte(in_data_byte, in_last_byte);
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || region_words_q.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          w = region_words_q.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= w.data;
          in_last_byte <= w.last;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 15);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Receiver: switch between random stall styles
  int stall_mode = 0;
  int mode_left = 0;
  int ready_tick = 0;
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(16, 96);
    end else begin
      mode_left--;
    end
    ready_tick++;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (ready_tick % 5 != 0);
    endcase
  end

  // Monitor: compare each accepted report with the oldest expectation
  always @(posedge clk) begin
    scan_report_t exp_rep;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected report: found=%0b offset=%08h", out_found, out_match_offset);
      end else begin
        exp_rep = expected_reports.pop_front();
        if (exp_rep.found) hits_seen++;
        else misses_seen++;
        if (out_found !== exp_rep.found || out_match_offset !== exp_rep.offset) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("report mismatch: expected found=%0b offset=%08h, got found=%0b offset=%08h",
                     exp_rep.found, exp_rep.offset, out_found, out_match_offset);
        end
      end
    end
  end

  // Write one register and mirror it in the shadow copy
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PAT0: pat_word[0] = val;
      REG_PAT1: pat_word[1] = val;
      REG_PAT2: pat_word[2] = val;
      REG_PAT3: pat_word[3] = val;
      REG_LEN:  len_reg = val[CFG_LEN_W-1:0];
      REG_BASE: base_reg = val[OFF_W-1:0];
      default: ;
    endcase
  endtask

  // Hold until every word is taken and every report has come, then let the pipe drain
  task automatic wait_idle();
    while (region_words_q.size() != 0 || in_valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic push_word(input logic [7:0] data, input logic last);
    region_word_t w;
    w.data = data;
    w.last = last;
    region_words_q.push_back(w);
    if (last) regions_sent++;
  endtask

  // Queue one region of n words, optionally with the pattern planted at a random spot
  task automatic queue_region(input int n, input bit plant, output int words);
    logic [7:0]  content [$];
    int unsigned ln;
    int          at;
    logic [7:0]  p;
    ln = eff_len();
    for (int k = 0; k < n; k++) begin
      p = pat_byte($urandom_range(0, ln - 1));
      if ($urandom_range(0, 1) == 1 && p != WILDCARD) content.push_back(p);
      else content.push_back(8'($urandom));
    end
    if (plant && n >= ln) begin
      at = $urandom_range(0, n - ln);
      for (int k = 0; k < ln; k++) begin
        if (pat_byte(k) != WILDCARD) content[at + k] = pat_byte(k);
      end
    end
    for (int k = 0; k < n; k++) push_word(content[k], k == n - 1);
    words = n;
  endtask

  // Load one random register setting; the first phases pin the extremes
  task automatic load_setting(input int ph);
    logic [CFG_W-1:0]     words [PAT_WORDS];
    logic [CFG_LEN_W-1:0] len_val;
    logic [OFF_W-1:0]     base_val;
    int                   wild_pct;
    logic [7:0]           b;
    wild_pct = $urandom_range(0, 3) * 20;
    for (int w = 0; w < PAT_WORDS; w++) begin
      for (int k = 0; k < 8; k++) begin
        b = ($urandom_range(1, 100) <= wild_pct) ? WILDCARD : 8'($urandom_range(0, 254));
        if (ph == 2) b = WILDCARD;
        if (ph == 5) b = 8'h00;
        words[w][k*8 +: 8] = b;
      end
    end
    case (ph)
      0: len_val = 6'd1;
      1: len_val = 6'd32;
      2: len_val = 6'd0;
      3: len_val = 6'd63;
      4: len_val = 6'd40;
      default: len_val = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(7, 32))
                                                     : 6'($urandom_range(2, 6));
    endcase
    case (ph % 4)
      0: base_val = 32'h0000_0000;
      1: base_val = 32'hFFFF_FFFF;
      2: base_val = 32'hFFFF_FFF0;
      default: base_val = $urandom;
    endcase
    write_reg(REG_PAT0, words[0]);
    write_reg(REG_PAT1, words[1]);
    write_reg(REG_PAT2, words[2]);
    write_reg(REG_PAT3, words[3]);
    // Odd phases put junk above the register width
    if (ph % 2 == 1) begin
      write_reg(REG_LEN, {$urandom, $urandom} & ~64'h3F | 64'(len_val));
      write_reg(REG_BASE, {32'($urandom), base_val});
    end else begin
      write_reg(REG_LEN, 64'(len_val));
      write_reg(REG_BASE, 64'(base_val));
    end
    settings_used++;
    repeat (2) @(posedge clk);
  endtask

  // Stimulus: reset, directed regions, then random phases
  initial begin
    int sent;
    int n;
    int r;
    int words;
    for (int w = 0; w < PAT_WORDS; w++) pat_word[w] = '0;
    len_reg = LEN_RESET;
    base_reg = '0;
    rearm_scan();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Pattern 00 ?? A5 5A, base 0x100
    write_reg(REG_PAT0, 64'h0000_0000_5AA5_FF00);
    write_reg(REG_LEN, 64'd4);
    write_reg(REG_BASE, 64'h100);
    settings_used++;
    repeat (2) @(posedge clk);
    // match on the final word
    push_word(8'h00, 0); push_word(8'hFF, 0); push_word(8'hA5, 0); push_word(8'h5A, 1);
    // match at the start, then words to drop
    push_word(8'h00, 0); push_word(8'h37, 0); push_word(8'hA5, 0); push_word(8'h5A, 0);
    push_word(8'h11, 0); push_word(8'h22, 1);
    // short regions
    push_word(8'h00, 0); push_word(8'hFF, 1);
    push_word(8'hFF, 1);
    // match in the middle
    push_word(8'hA5, 0); push_word(8'h00, 0); push_word(8'h00, 0); push_word(8'h12, 0);
    push_word(8'hA5, 0); push_word(8'h5A, 0); push_word(8'h00, 1);
    // a literal 0xFF in the data is no wildcard: no match
    push_word(8'h00, 0); push_word(8'hFF, 0); push_word(8'hA5, 0); push_word(8'hFF, 1);
    wait_idle();

    for (int ph = 0; ph < 10; ph++) begin
      load_setting(ph);
      sent = 0;
      while (sent < 128) begin
        r = $urandom_range(0, 9);
        if (r < 6) n = $urandom_range(1, 48);
        else if (r < 8) n = $urandom_range(eff_len(), eff_len() + 10);
        else n = $urandom_range(1, 100);
        queue_region(n, $urandom_range(0, 99) < 60, words);
        sent += words;
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    $display("covered %0d regions over %0d register settings", regions_sent, settings_used);
    $display("reports checked: %0d matches, %0d regions without a match", hits_seen, misses_seen);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total", mismatch_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("timeout waiting for the scanner");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
